// ===== hw/rtl/irpd_pkg.sv =====
package irpd_pkg;

   localparam int unsigned TS_W    = 16;
   localparam int unsigned CODE_W  = 8;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [TS_W-1:0]   PREP_MIN    = 16'd480;
   localparam logic [TS_W-1:0]   PREP_MAX    = 16'd640;
   localparam logic [7:0]        ABORT_TICKS = 8'd8;
   localparam logic [TS_W-1:0]   HOLD_TICKS  = 16'd20;
   localparam logic [TS_W-1:0]   IDLE_TICKS  = 16'd100;

   localparam logic [CSR_IDX_W-1:0] REG_LEADER_MIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEADER_MAX  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REPEAT_MIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_REPEAT_MAX  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MARK_NOM    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_NOM     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_NOM    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_TOLERANCE   = 3'd7;

   localparam logic FUNC_EDGE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   typedef struct packed {
      logic [TS_W-1:0] leader_min;
      logic [TS_W-1:0] leader_max;
      logic [TS_W-1:0] repeat_min;
      logic [TS_W-1:0] repeat_max;
      logic [TS_W-1:0] mark_nominal;
      logic [TS_W-1:0] one_space_nominal;
      logic [TS_W-1:0] zero_space_nominal;
      logic [TS_W-1:0] tolerance;
   } cfg_type;

   typedef struct packed {
      logic            func;
      logic            carrier_on;
      logic [TS_W-1:0] timestamp;
   } req_item_type;

   typedef struct packed {
      logic              frame_busy;
      logic [CODE_W-1:0] key_code;
   } rsp_item_type;

   // exclusive window check
   function automatic logic in_window(input logic [TS_W-1:0] t,
                                      input logic [TS_W-1:0] lo,
                                      input logic [TS_W-1:0] hi);
      in_window = (t > lo) && (t < hi);
   endfunction

endpackage

// ===== hw/rtl/irpd_csr.sv =====
module irpd_csr
   import irpd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [CSR_IDX_W-1:0] wr_index,
   input  logic [TS_W-1:0]      wr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            REG_LEADER_MIN: cfg_in.leader_min         = wr_data;
            REG_LEADER_MAX: cfg_in.leader_max         = wr_data;
            REG_REPEAT_MIN: cfg_in.repeat_min         = wr_data;
            REG_REPEAT_MAX: cfg_in.repeat_max         = wr_data;
            REG_MARK_NOM:   cfg_in.mark_nominal       = wr_data;
            REG_ONE_NOM:    cfg_in.one_space_nominal  = wr_data;
            REG_ZERO_NOM:   cfg_in.zero_space_nominal = wr_data;
            REG_TOLERANCE:  cfg_in.tolerance          = wr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leader_min         <= 16'd1000;
         cfg_ff.leader_max         <= 16'd1250;
         cfg_ff.repeat_min         <= 16'd250;
         cfg_ff.repeat_max         <= 16'd320;
         cfg_ff.mark_nominal       <= 16'd70;
         cfg_ff.one_space_nominal  <= 16'd211;
         cfg_ff.zero_space_nominal <= 16'd70;
         cfg_ff.tolerance          <= 16'd20;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/irpd_engine.sv =====
module irpd_engine
   import irpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   localparam logic [2:0] ST_IDLE         = 3'd0;
   localparam logic [2:0] ST_LEADER       = 3'd1;
   localparam logic [2:0] ST_LEADER_SPACE = 3'd2;
   localparam logic [2:0] ST_MARK         = 3'd3;
   localparam logic [2:0] ST_SPACE        = 3'd4;
   localparam logic [2:0] ST_REP_SPACE    = 3'd5;
   localparam logic [2:0] ST_REP_MARK     = 3'd6;

   localparam logic [5:0] FULL_BITS = 6'd32;

   logic [2:0]        fsm_state_ff, fsm_state_in;
   logic              last_level_ff, last_level_in;
   logic [TS_W-1:0]   edge_time_ff, edge_time_in;
   logic [31:0]       shift_ff, shift_in;
   logic [5:0]        bit_count_ff, bit_count_in;
   logic [CODE_W-1:0] held_code_ff, held_code_in;
   logic              code_ready_ff, code_ready_in;
   logic              in_frame_ff, in_frame_in;
   logic [7:0]        abort_count_ff, abort_count_in;
   logic [TS_W-1:0]   hold_count_ff, hold_count_in;
   logic [TS_W-1:0]   idle_count_ff, idle_count_in;
   logic [CODE_W-1:0] prev_code_ff, prev_code_in;

   logic [TS_W-1:0] dt;
   logic [TS_W-1:0] mark_lo, mark_hi, one_lo, one_hi, zero_lo, zero_hi;
   rsp_item_type    res;

   assign dt      = item.timestamp - edge_time_ff;
   assign mark_lo = cfg.mark_nominal - cfg.tolerance;
   assign mark_hi = cfg.mark_nominal + cfg.tolerance;
   assign one_lo  = cfg.one_space_nominal - cfg.tolerance;
   assign one_hi  = cfg.one_space_nominal + cfg.tolerance;
   assign zero_lo = cfg.zero_space_nominal - cfg.tolerance;
   assign zero_hi = cfg.zero_space_nominal + cfg.tolerance;

   always_comb begin
      fsm_state_in   = fsm_state_ff;
      last_level_in  = last_level_ff;
      edge_time_in   = edge_time_ff;
      shift_in       = shift_ff;
      bit_count_in   = bit_count_ff;
      held_code_in   = held_code_ff;
      code_ready_in  = code_ready_ff;
      in_frame_in    = in_frame_ff;
      abort_count_in = abort_count_ff;
      hold_count_in  = hold_count_ff;
      idle_count_in  = idle_count_ff;
      prev_code_in   = prev_code_ff;
      res            = '0;

      if (item.func == FUNC_EDGE) begin
         if (item.carrier_on != last_level_ff) begin
            last_level_in = item.carrier_on;
            case (fsm_state_ff)
               ST_LEADER: begin
                  if (!item.carrier_on) begin
                     if (in_window(dt, cfg.leader_min, cfg.leader_max)) begin
                        fsm_state_in = ST_LEADER_SPACE;
                        edge_time_in = item.timestamp;
                        in_frame_in  = 1'b1;
                     end else if (in_window(dt, cfg.repeat_min, cfg.repeat_max)) begin
                        fsm_state_in = ST_REP_SPACE;
                        edge_time_in = item.timestamp;
                        in_frame_in  = 1'b1;
                     end else begin
                        fsm_state_in = ST_IDLE;
                     end
                  end
               end
               ST_LEADER_SPACE: begin
                  if (item.carrier_on) begin
                     if (in_window(dt, PREP_MIN, PREP_MAX)) begin
                        fsm_state_in = ST_MARK;
                        in_frame_in  = 1'b1;
                        shift_in     = '0;
                        bit_count_in = '0;
                        edge_time_in = item.timestamp;
                     end else begin
                        code_ready_in = 1'b0;
                        in_frame_in   = 1'b0;
                        fsm_state_in  = ST_IDLE;
                     end
                  end
               end
               ST_MARK: begin
                  if (!item.carrier_on && in_window(dt, mark_lo, mark_hi)) begin
                     edge_time_in = item.timestamp;
                     if (bit_count_ff == FULL_BITS) begin
                        code_ready_in = 1'b1;
                        in_frame_in   = 1'b0;
                        fsm_state_in  = ST_IDLE;
                        held_code_in  = shift_ff[CODE_W-1:0];
                     end else begin
                        bit_count_in = bit_count_ff + 6'd1;
                        shift_in     = {shift_ff[30:0], 1'b0};
                        fsm_state_in = ST_SPACE;
                     end
                  end
               end
               ST_SPACE: begin
                  if (item.carrier_on) begin
                     if ((dt > one_hi) && in_frame_ff) begin
                        code_ready_in = 1'b0;
                        in_frame_in   = 1'b0;
                        fsm_state_in  = ST_IDLE;
                     end else if (in_window(dt, one_lo, one_hi)) begin
                        edge_time_in = item.timestamp;
                        shift_in     = shift_ff + 32'd1;
                        fsm_state_in = ST_MARK;
                     end else if (in_window(dt, zero_lo, zero_hi)) begin
                        edge_time_in = item.timestamp;
                        fsm_state_in = ST_MARK;
                     end
                  end
               end
               ST_REP_SPACE: begin
                  edge_time_in = item.timestamp;
                  fsm_state_in = ST_REP_MARK;
               end
               ST_REP_MARK: begin
                  code_ready_in = 1'b1;
                  in_frame_in   = 1'b0;
                  edge_time_in  = item.timestamp;
                  fsm_state_in  = ST_IDLE;
                  held_code_in  = shift_ff[CODE_W-1:0];
               end
               default: begin
                  if (item.carrier_on) begin
                     edge_time_in  = item.timestamp;
                     fsm_state_in  = ST_LEADER;
                     code_ready_in = 1'b0;
                     in_frame_in   = 1'b0;
                  end
               end
            endcase
         end
      end else begin
         // abort timeout
         res.frame_busy = in_frame_ff;
         if (in_frame_ff) begin
            abort_count_in = abort_count_ff + 8'd1;
            if (abort_count_in > ABORT_TICKS) begin
               code_ready_in  = 1'b0;
               in_frame_in    = 1'b0;
               fsm_state_in   = ST_IDLE;
               abort_count_in = '0;
               shift_in       = '0;
            end
         end else begin
            abort_count_in = '0;
         end
         // code delivery
         if (hold_count_ff != '0) begin
            hold_count_in = hold_count_ff - 16'd1;
         end
         if (idle_count_ff != '0) begin
            idle_count_in = idle_count_ff - 16'd1;
         end else if (fsm_state_in == ST_IDLE) begin
            shift_in     = '0;
            held_code_in = '0;
         end
         if (code_ready_in) begin
            if ((held_code_in == prev_code_ff) && (hold_count_in != '0)) begin
               res.key_code = '0;
            end else begin
               res.key_code  = held_code_in;
               hold_count_in = HOLD_TICKS;
            end
            code_ready_in = 1'b0;
            in_frame_in   = 1'b0;
            fsm_state_in  = ST_IDLE;
            prev_code_in  = held_code_in;
            idle_count_in = IDLE_TICKS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_state_ff   <= ST_IDLE;
         last_level_ff  <= 1'b1;
         edge_time_ff   <= '0;
         shift_ff       <= '0;
         bit_count_ff   <= '0;
         held_code_ff   <= '0;
         code_ready_ff  <= 1'b0;
         in_frame_ff    <= 1'b0;
         abort_count_ff <= '0;
         hold_count_ff  <= '0;
         idle_count_ff  <= '0;
         prev_code_ff   <= '0;
      end else if (fire) begin
         fsm_state_ff   <= fsm_state_in;
         last_level_ff  <= last_level_in;
         edge_time_ff   <= edge_time_in;
         shift_ff       <= shift_in;
         bit_count_ff   <= bit_count_in;
         held_code_ff   <= held_code_in;
         code_ready_ff  <= code_ready_in;
         in_frame_ff    <= in_frame_in;
         abort_count_ff <= abort_count_in;
         hold_count_ff  <= hold_count_in;
         idle_count_ff  <= idle_count_in;
         prev_code_ff   <= prev_code_in;
      end
   end

   assign result = res;

endmodule

// ===== hw/rtl/ir_remote_pulse_decoder.sv =====
// channel   | handshake             | payload
// req       | req_valid/req_ready   | req_func, req_carrier_on, req_timestamp
// rsp       | rsp_valid/rsp_ready   | rsp_frame_busy, rsp_key_code
// csr       | csr_valid/csr_ready   | csr_index, csr_wdata
//
// One item per cycle sustained while rsp_ready is high. An accepted item passes
// the input register, then the decode logic into the result register, where
// rsp_valid rises and the earliest rsp handshake can follow.
// Synchronous reset idles the decoder; all but the item registers get defaults.
// A stalled rsp holds its item; the input register still takes one more item,
// then req_ready drops until the result register drains. csr_ready is always high.
module ir_remote_pulse_decoder
   import irpd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_func,
   input  logic                 req_carrier_on,
   input  logic [TS_W-1:0]      req_timestamp,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_frame_busy,
   output logic [CODE_W-1:0]    rsp_key_code,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TS_W-1:0]      csr_wdata
);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type result;
   cfg_type      cfg;
   logic         proc_fire;
   logic         req_fire;

   assign csr_ready = 1'b1;
   assign proc_fire = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || proc_fire;
   assign req_fire  = req_valid && req_ready;

   irpd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   irpd_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (proc_fire),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (proc_fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (proc_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= '{func: req_func, carrier_on: req_carrier_on,
                         timestamp: req_timestamp};
      end
      if (proc_fire) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_busy = rsp_item_ff.frame_busy;
   assign rsp_key_code   = rsp_item_ff.key_code;

   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      proc_fire |=> rsp_valid)
      else $error("processed item did not reach the result register");

   a_edge_result_zero: assert property (@(posedge clock) disable iff (reset)
      (proc_fire && (in_item_ff.func == FUNC_EDGE)) |=>
         (!rsp_frame_busy && (rsp_key_code == '0)))
      else $error("edge item produced a nonzero result");

   a_held_item_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !proc_fire) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("pending input item lost or changed");

   a_rsp_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> !proc_fire || $past(proc_fire) || rsp_valid)
      else $error("result register overwritten while stalled");

endmodule
